/* rtl/mesh_point_hit_test_macros.svh */
// assertion helpers for the hit test block
`ifndef MESH_POINT_HIT_TEST_MACROS_SVH
`define MESH_POINT_HIT_TEST_MACROS_SVH

// same-cycle implication, checked out of reset
`define MPH_ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("mesh_point_hit_test: check failed");

// next-cycle implication, checked out of reset
`define MPH_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("mesh_point_hit_test: check failed");

`endif

/* rtl/mph_pkg.sv */
package mph_pkg;

  localparam int VERTEX_DEPTH_DEF = 1024;
  localparam int INDEX_DEPTH_DEF  = 4096;

  // field widths
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 12;
  localparam int COORD_W  = 32;
  localparam int IDXV_W   = 16;
  localparam int VCNT_W   = 11;
  localparam int ICNT_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 8;

  // counters wide enough for any depth up to 65536
  localparam int CNT_W = 17;

  // ndc points and divider widths
  localparam int NDC_W  = 30;
  localparam int DIVD_W = 48;
  localparam int QUOT_W = 49;
  localparam int WDIV_W = 31;

  localparam logic signed [QUOT_W-1:0] NDC_MAX = 49'sd536870911;
  localparam logic signed [QUOT_W-1:0] NDC_MIN = -49'sd536870912;
  localparam logic signed [QUOT_W-1:0] Z_MAX   = 49'sd65536;
  localparam logic signed [QUOT_W-1:0] Z_MIN   = -49'sd65536;
  localparam logic signed [62:0] DEGEN_LIMIT   = 63'sd4294967;

  typedef enum logic [KIND_W-1:0] {
    KIND_MATRIX = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_INDEX  = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_COUNT  = 2'd1;

  typedef logic signed [NDC_W-1:0] ndc_t;

  typedef struct packed {
    ndc_t x;
    ndc_t y;
  } pt_t;

  // clamp to the ndc range
  function automatic ndc_t sat_ndc(logic signed [QUOT_W-1:0] v);
    ndc_t r;
    if (v > NDC_MAX) begin
      r = NDC_MAX[NDC_W-1:0];
    end else if (v < NDC_MIN) begin
      r = NDC_MIN[NDC_W-1:0];
    end else begin
      r = v[NDC_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/mph_div.sv */
module mph_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mph_pkg::DIVD_W-1:0]   dividend,
  input  logic        [mph_pkg::WDIV_W-1:0]   divisor,
  output logic                                done,
  output logic signed [mph_pkg::QUOT_W-1:0]   quot
);
  import mph_pkg::*;

  logic                busy_r;
  logic [5:0]          cnt_r;
  logic [DIVD_W-1:0]   dvd_r;
  logic [WDIV_W-1:0]   rem_r;
  logic [WDIV_W-1:0]   dsr_r;
  logic                neg_r;
  logic                done_r;
  logic [WDIV_W:0]     rem_sh;
  logic [WDIV_W:0]     rem_sub;
  logic                fits;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIVD_W-1]};
    fits    = rem_sh >= {1'b0, dsr_r};
    rem_sub = rem_sh - {1'b0, dsr_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIVD_W-1];
      dvd_r <= dividend[DIVD_W-1] ? DIVD_W'(-dividend) : dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[WDIV_W-1:0] : rem_sh[WDIV_W-1:0];
      dvd_r <= {dvd_r[DIVD_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

endmodule

/* rtl/mph_proj.sv */
module mph_proj (
  input  logic                               clk,
  input  logic                               rst_n,
  // matrix store write port
  input  logic                               mwe,
  input  logic [3:0]                         mwaddr,
  input  logic [mph_pkg::COORD_W-1:0]        mwdata,
  // one vertex in, projected point out
  input  logic                               start,
  input  logic signed [mph_pkg::COORD_W-1:0] vx,
  input  logic signed [mph_pkg::COORD_W-1:0] vy,
  input  logic signed [mph_pkg::COORD_W-1:0] vz,
  output logic                               done,
  output logic                               visible,
  output mph_pkg::pt_t                       pt
);
  import mph_pkg::*;

  typedef enum logic [2:0] {P_IDLE, P_MAC, P_W, P_DZ, P_DX, P_DY} pstate_t;

  localparam int ACC_W = 50;

  pstate_t state_r;
  logic [4:0] k_r;
  logic done_r, vis_r;

  logic [COORD_W-1:0] mem [16];
  logic signed [COORD_W-1:0] mdata_r;
  logic rd_v_r, mul_v_r;
  logic [3:0] rd_k_r, mul_k_r;
  logic signed [ACC_W-1:0] term_r, acc_r;
  logic signed [COORD_W-1:0] vx_r, vy_r, vz_r;
  logic signed [COORD_W-1:0] clip_r [4];
  ndc_t nx_r, ny_r;

  logic signed [COORD_W-1:0] vsel;
  logic signed [2*COORD_W-1:0] prod;
  logic signed [2*COORD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0] term_nxt, sum;

  logic div_start, div_done;
  logic signed [DIVD_W-1:0] div_dvd;
  logic signed [QUOT_W-1:0] div_q;

  function automatic logic signed [COORD_W-1:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > ACC_W'(64'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -ACC_W'(64'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // matrix store: write on load, registered read while walking
  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[mwaddr] <= mwdata;
    end
    mdata_r <= mem[k_r[3:0]];
  end

  // multiply stage: floor(m * v / 2^16), or the translation column as is
  always_comb begin
    case (rd_k_r[1:0])
      2'd0:    vsel = vx_r;
      2'd1:    vsel = vy_r;
      default: vsel = vz_r;
    endcase
    prod    = mdata_r * vsel;
    prod_sh = prod >>> 16;
    if (rd_k_r[1:0] == 2'd3) begin
      term_nxt = ACC_W'(mdata_r);
    end else begin
      term_nxt = ACC_W'(prod_sh);
    end
    sum = ((mul_k_r[1:0] == 2'd0) ? '0 : acc_r) + term_r;
  end

  // divider operand per state
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    unique case (state_r)
      P_W: begin
        div_start = clip_r[3] > 0;
        div_dvd   = DIVD_W'(clip_r[2]) <<< 16;
      end
      P_DZ: begin
        div_start = div_done && div_q >= Z_MIN && div_q <= Z_MAX;
        div_dvd   = DIVD_W'(clip_r[0]) <<< 16;
      end
      P_DX: begin
        div_start = div_done;
        div_dvd   = DIVD_W'(clip_r[1]) <<< 16;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  mph_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (clip_r[3][WDIV_W-1:0]),
    .done     (div_done),
    .quot     (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      k_r     <= '0;
      done_r  <= 1'b0;
      vis_r   <= 1'b0;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      done_r  <= 1'b0;
      rd_v_r  <= (state_r == P_MAC) && !k_r[4];
      mul_v_r <= rd_v_r;
      unique case (state_r)
        P_IDLE: begin
          if (start) begin
            k_r     <= '0;
            state_r <= P_MAC;
          end
        end
        P_MAC: begin
          if (!k_r[4]) begin
            k_r <= k_r + 5'd1;
          end
          if (mul_v_r && mul_k_r == 4'd15) begin
            state_r <= P_W;
          end
        end
        P_W: begin
          if (clip_r[3] <= 0) begin
            done_r  <= 1'b1;
            vis_r   <= 1'b0;
            state_r <= P_IDLE;
          end else begin
            state_r <= P_DZ;
          end
        end
        P_DZ: begin
          if (div_done) begin
            if (div_start) begin
              state_r <= P_DX;
            end else begin
              done_r  <= 1'b1;
              vis_r   <= 1'b0;
              state_r <= P_IDLE;
            end
          end
        end
        P_DX: begin
          if (div_done) begin
            state_r <= P_DY;
          end
        end
        P_DY: begin
          if (div_done) begin
            done_r  <= 1'b1;
            vis_r   <= 1'b1;
            state_r <= P_IDLE;
          end
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && state_r == P_IDLE) begin
      vx_r <= vx;
      vy_r <= vy;
      vz_r <= vz;
    end
    rd_k_r  <= k_r[3:0];
    mul_k_r <= rd_k_r;
    term_r  <= term_nxt;
    if (mul_v_r) begin
      acc_r <= sum;
      if (mul_k_r[1:0] == 2'd3) begin
        clip_r[mul_k_r[3:2]] <= sat32(sum);
      end
    end
    if (div_done && state_r == P_DX) begin
      nx_r <= sat_ndc(div_q);
    end
    if (div_done && state_r == P_DY) begin
      ny_r <= sat_ndc(div_q);
    end
  end

  assign done    = done_r;
  assign visible = vis_r;
  assign pt.x    = nx_r;
  assign pt.y    = ny_r;

endmodule

/* rtl/mph_tri.sv */
module mph_tri (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mph_pkg::pt_t  pa,
  input  mph_pkg::pt_t  pb,
  input  mph_pkg::pt_t  pc,
  input  mph_pkg::pt_t  pq,
  output logic          done,
  output logic          hit
);
  import mph_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_MUL, T_DEC} tstate_t;

  localparam int DW = NDC_W + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  tstate_t state_r;
  logic [2:0] s_r, ps_r;
  logic pv_r;
  logic done_r, hit_r;
  logic signed [DW-1:0] v0x_r, v0y_r, v1x_r, v1y_r, v2x_r, v2y_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] d_r, nu_r, nv_r;
  logic signed [DW-1:0] opa, opb;
  logic signed [SW-1:0] acc_sel, acc_new;
  logic signed [SW:0]   uv;
  logic degen, inside_t;

  // operand pairs of the three cross products
  always_comb begin
    case (s_r)
      3'd0:    begin opa = v0x_r; opb = v1y_r; end
      3'd1:    begin opa = v0y_r; opb = v1x_r; end
      3'd2:    begin opa = v2x_r; opb = v1y_r; end
      3'd3:    begin opa = v2y_r; opb = v1x_r; end
      3'd4:    begin opa = v0x_r; opb = v2y_r; end
      default: begin opa = v0y_r; opb = v2x_r; end
    endcase
    case (ps_r[2:1])
      2'd0:    acc_sel = d_r;
      2'd1:    acc_sel = nu_r;
      default: acc_sel = nv_r;
    endcase
    acc_new = ps_r[0] ? (acc_sel - SW'(prod_r)) : SW'(prod_r);
  end

  // exact inside test, no division
  always_comb begin
    uv       = (SW+1)'(nu_r) + (SW+1)'(nv_r);
    degen    = (d_r <= SW'(DEGEN_LIMIT)) && (d_r >= -SW'(DEGEN_LIMIT));
    if (d_r > 0) begin
      inside_t = nu_r >= 0 && nv_r >= 0 && uv <= (SW+1)'(d_r);
    end else begin
      inside_t = nu_r <= 0 && nv_r <= 0 && uv >= (SW+1)'(d_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      s_r     <= '0;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      pv_r   <= (state_r == T_MUL) && s_r <= 3'd5;
      unique case (state_r)
        T_IDLE: begin
          if (start) begin
            s_r     <= '0;
            state_r <= T_MUL;
          end
        end
        T_MUL: begin
          if (s_r <= 3'd5) begin
            s_r <= s_r + 3'd1;
          end
          if (pv_r && ps_r == 3'd5) begin
            state_r <= T_DEC;
          end
        end
        T_DEC: begin
          done_r  <= 1'b1;
          state_r <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // edge vectors, one product a cycle, each accumulated in the following cycle
  always_ff @(posedge clk) begin
    if (start && state_r == T_IDLE) begin
      v0x_r <= DW'(pc.x) - DW'(pa.x);
      v0y_r <= DW'(pc.y) - DW'(pa.y);
      v1x_r <= DW'(pb.x) - DW'(pa.x);
      v1y_r <= DW'(pb.y) - DW'(pa.y);
      v2x_r <= DW'(pq.x) - DW'(pa.x);
      v2y_r <= DW'(pq.y) - DW'(pa.y);
    end
    prod_r <= opa * opb;
    ps_r   <= s_r;
    if (pv_r) begin
      case (ps_r[2:1])
        2'd0:    d_r  <= acc_new;
        2'd1:    nu_r <= acc_new;
        default: nv_r <= acc_new;
      endcase
    end
    if (state_r == T_DEC) begin
      hit_r <= !degen && inside_t;
    end
  end

  assign done = done_r;
  assign hit  = hit_r;

endmodule

/* rtl/mesh_point_hit_test.sv */
// Point hit test against a triangle mesh projected by a 4x4 matrix, Q16.16.
// Input channel in_*: in_tuser is the item kind (matrix word, vertex, index
// word, query). Loads are taken one per cycle while no query is walking and no
// result waits, and produce no output item. A query walks every complete index
// triple: three index reads, then for each vertex a vertex read, a 16-step
// multiply-accumulate over the matrix store and up to three divisions, then a
// 6-product inside test. It stops at the first hit and skips triangles that
// fail the index range or the visibility check. The output item (out_tdata
// bit 0 = hit) sits in a register; while the receiver stalls it holds, loads
// are still taken, and a following query waits only when its own result is
// ready to go. Configuration writes on cfg_* set vertex_count and index_count;
// the user must make them only while idle, which the block does not enforce.
// Reset clears counts, the sequencers and the output valid; the stores are left
// as they are and must be written before they are read.
module mesh_point_hit_test #(
  parameter int VERTEX_DEPTH = mph_pkg::VERTEX_DEPTH_DEF,
  parameter int INDEX_DEPTH  = mph_pkg::INDEX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // slot[11:0], coord_x[43:12], coord_y[75:44], coord_z[107:76],
  // index_value[123:108], zero above
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mph_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind[1:0]
  input  logic [mph_pkg::KIND_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit[0], zero above
  output logic [mph_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mph_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mph_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import mph_pkg::*;

  `include "mesh_point_hit_test_macros.svh"

  localparam int VA_W = $clog2(VERTEX_DEPTH);
  localparam int IA_W = $clog2(INDEX_DEPTH);
  localparam logic [CNT_W-1:0] VD = CNT_W'(VERTEX_DEPTH);
  localparam logic [CNT_W-1:0] ID = CNT_W'(INDEX_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_TRI, S_IDX, S_CHK, S_VRD, S_VWT, S_PROJ, S_TST
  } state_t;

  state_t state_r;
  logic emit_r, res_r;
  logic out_tvalid_r, out_hit_r;
  logic [VCNT_W-1:0] vcount_r;
  logic [ICNT_W-1:0] icount_r;
  logic [CNT_W-1:0]  vc_r, ic_r, i_r;
  logic [1:0]        j_r, vj_r;
  logic [IDXV_W-1:0] idx_r [3];
  pt_t               pts_r [3];
  pt_t               qp_r;

  logic [3*COORD_W-1:0] vmem [VERTEX_DEPTH];
  logic [IDXV_W-1:0]    imem [INDEX_DEPTH];
  logic [3*COORD_W-1:0] vrd_r;
  logic [IDXV_W-1:0]    ird_r;

  kind_t kind;
  logic [SLOT_W-1:0] slot;
  logic signed [COORD_W-1:0] cx, cy, cz;
  logic [IDXV_W-1:0] iv;
  logic [CNT_W-1:0]  slot_x, iaddr, vaddr, vc_nxt, ic_nxt;
  logic accept, is_load_v, is_load_i, mwe;
  logic out_free;

  logic proj_start, proj_done, proj_vis;
  pt_t  proj_pt;
  logic tri_start, tri_done, tri_hit;

  // input unpacking
  always_comb begin
    kind   = kind_t'(in_tuser);
    slot   = in_tdata[11:0];
    cx     = in_tdata[43:12];
    cy     = in_tdata[75:44];
    cz     = in_tdata[107:76];
    iv     = in_tdata[123:108];
    slot_x = CNT_W'(slot);
  end

  assign in_tready = (state_r == S_IDLE) && !emit_r;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign mwe       = accept && kind == KIND_MATRIX && slot < SLOT_W'(16);
  assign is_load_v = accept && kind == KIND_VERTEX && slot_x < VD;
  assign is_load_i = accept && kind == KIND_INDEX && slot_x < ID;
  assign out_free  = !out_tvalid_r || out_tready;

  // counts clipped to the store depths
  always_comb begin
    vc_nxt = (CNT_W'(vcount_r) < VD) ? CNT_W'(vcount_r) : VD;
    ic_nxt = (CNT_W'(icount_r) < ID) ? CNT_W'(icount_r) : ID;
    iaddr  = i_r + CNT_W'(j_r);
    vaddr  = CNT_W'(idx_r[vj_r]);
  end

  // vertex and index stores
  always_ff @(posedge clk) begin
    if (is_load_v) begin
      vmem[slot_x[VA_W-1:0]] <= {cz, cy, cx};
    end
    if (is_load_i) begin
      imem[slot_x[IA_W-1:0]] <= iv;
    end
    vrd_r <= vmem[vaddr[VA_W-1:0]];
    ird_r <= imem[iaddr[IA_W-1:0]];
  end

  assign proj_start = state_r == S_VWT;
  assign tri_start  = (state_r == S_PROJ) && proj_done && proj_vis && vj_r == 2'd2;

  mph_proj u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .mwe     (mwe),
    .mwaddr  (slot[3:0]),
    .mwdata  (cx),
    .start   (proj_start),
    .vx      (vrd_r[COORD_W-1:0]),
    .vy      (vrd_r[2*COORD_W-1:COORD_W]),
    .vz      (vrd_r[3*COORD_W-1:2*COORD_W]),
    .done    (proj_done),
    .visible (proj_vis),
    .pt      (proj_pt)
  );

  mph_tri u_tri (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tri_start),
    .pa    (pts_r[0]),
    .pb    (pts_r[1]),
    .pc    (proj_pt),
    .pq    (qp_r),
    .done  (tri_done),
    .hit   (tri_hit)
  );

  // query walk and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      emit_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      vcount_r     <= '0;
      icount_r     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_VERTEX_COUNT: vcount_r <= cfg_data[VCNT_W-1:0];
          CFG_INDEX_COUNT:  icount_r <= cfg_data;
          default:          ;
        endcase
      end
      if (emit_r && out_free) begin
        out_tvalid_r <= 1'b1;
        out_hit_r    <= res_r;
        emit_r       <= 1'b0;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && kind == KIND_QUERY) begin
            qp_r.x  <= sat_ndc(QUOT_W'(cx));
            qp_r.y  <= sat_ndc(QUOT_W'(cy));
            vc_r    <= vc_nxt;
            ic_r    <= ic_nxt;
            i_r     <= '0;
            state_r <= S_TRI;
          end
        end
        S_TRI: begin
          if ((CNT_W+1)'(i_r) + (CNT_W+1)'(2) >= (CNT_W+1)'(ic_r)) begin
            res_r   <= 1'b0;
            emit_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            j_r     <= '0;
            state_r <= S_IDX;
          end
        end
        S_IDX: begin
          j_r <= j_r + 2'd1;
          if (j_r != 2'd0) begin
            idx_r[j_r - 2'd1] <= ird_r;
          end
          if (j_r == 2'd3) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (CNT_W'(idx_r[0]) < vc_r && CNT_W'(idx_r[1]) < vc_r &&
              CNT_W'(idx_r[2]) < vc_r) begin
            vj_r    <= '0;
            state_r <= S_VRD;
          end else begin
            i_r     <= i_r + CNT_W'(3);
            state_r <= S_TRI;
          end
        end
        S_VRD: begin
          state_r <= S_VWT;
        end
        S_VWT: begin
          state_r <= S_PROJ;
        end
        S_PROJ: begin
          if (proj_done) begin
            if (!proj_vis) begin
              i_r     <= i_r + CNT_W'(3);
              state_r <= S_TRI;
            end else if (vj_r == 2'd2) begin
              state_r <= S_TST;
            end else begin
              pts_r[vj_r] <= proj_pt;
              vj_r        <= vj_r + 2'd1;
              state_r     <= S_VRD;
            end
          end
        end
        S_TST: begin
          if (tri_done) begin
            if (tri_hit) begin
              res_r   <= 1'b1;
              emit_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + CNT_W'(3);
              state_r <= S_TRI;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_hit_r};

  // checks
  `MPH_ASSERT_NOW(a_proj_done_waited, clk, rst_n, proj_done, state_r == S_PROJ)
  `MPH_ASSERT_NOW(a_tri_done_waited, clk, rst_n, tri_done, state_r == S_TST)
  `MPH_ASSERT_NEXT(a_walk_holds_input, clk, rst_n, tri_start, !in_tready)
  `MPH_ASSERT_NEXT(a_emit_once, clk, rst_n, emit_r && out_free, out_tvalid && !emit_r)

endmodule

/* sim/tb_mesh_point_hit_test.sv */
module tb_mesh_point_hit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mph_pkg::*;

  localparam int VDEPTH = 1024;
  localparam int IDEPTH = 4096;
  localparam longint NDC_HI = 64'sd536870911;
  localparam longint NDC_LO = -64'sd536870912;
  localparam longint DEGEN_MAX = 64'sd4294967;
  localparam longint ONE = 64'sd65536;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [12:0]  cfg_data;

  mesh_point_hit_test dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the block state
  longint mat [16];
  longint vtx_x [VDEPTH];
  longint vtx_y [VDEPTH];
  longint vtx_z [VDEPTH];
  int     idx_mem [IDEPTH];
  int     vert_count;
  int     index_count;

  bit     expected_hits [$];
  int     errors;
  int     items_sent;
  int     queries_sent;
  int     hits_seen;
  int     results_seen;
  int     send_idle_pct;
  int     recv_stall_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // overall limit
  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // transform one vertex to ndc; returns 0 when not visible
  function automatic bit project_vertex(int vi, output longint nx, output longint ny);
    longint clip [4];
    longint acc;
    longint vin [3];
    longint qz;
    vin[0] = vtx_x[vi];
    vin[1] = vtx_y[vi];
    vin[2] = vtx_z[vi];
    nx = 0;
    ny = 0;
    for (int r = 0; r < 4; r++) begin
      acc = mat[r*4+3];
      for (int c = 0; c < 3; c++) acc += (mat[r*4+c] * vin[c]) >>> 16;
      clip[r] = sat(acc, -64'sd2147483648, 64'sd2147483647);
    end
    if (clip[3] <= 0) return 1'b0;
    qz = (clip[2] * ONE) / clip[3];
    if (qz < -ONE || qz > ONE) return 1'b0;
    nx = sat((clip[0] * ONE) / clip[3], NDC_LO, NDC_HI);
    ny = sat((clip[1] * ONE) / clip[3], NDC_LO, NDC_HI);
    return 1'b1;
  endfunction

  // exact barycentric inside test, no division
  function automatic bit point_in_tri(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by, longint cx, longint cy);
    longint d, nu, nv;
    d  = (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
    nu = (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    nv = (cx - ax) * (py - ay) - (cy - ay) * (px - ax);
    if (d <= DEGEN_MAX && d >= -DEGEN_MAX) return 1'b0;
    if (d > 0) return nu >= 0 && nv >= 0 && nu + nv <= d;
    return nu <= 0 && nv <= 0 && nu + nv >= d;
  endfunction

  function automatic bit predict_hit(longint qx, longint qy);
    int vc, ic, ia, ib, icc;
    longint ax, ay, bx, by, cx, cy;
    vc = vert_count < VDEPTH ? vert_count : VDEPTH;
    ic = index_count < IDEPTH ? index_count : IDEPTH;
    qx = sat(qx, NDC_LO, NDC_HI);
    qy = sat(qy, NDC_LO, NDC_HI);
    for (int i = 0; i + 2 < ic; i += 3) begin
      ia = idx_mem[i];
      ib = idx_mem[i+1];
      icc = idx_mem[i+2];
      if (ia >= vc || ib >= vc || icc >= vc) continue;
      if (!project_vertex(ia, ax, ay)) continue;
      if (!project_vertex(ib, bx, by)) continue;
      if (!project_vertex(icc, cx, cy)) continue;
      if (point_in_tri(qx, qy, ax, ay, bx, by, cx, cy)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // send one item and update the shadow state when it is taken
  task automatic send_item(kind_t k, logic [11:0] slot, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [15:0] iv);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {4'b0, iv, z, y, x, slot};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    case (k)
      KIND_MATRIX: if (slot < 16) mat[slot] = longint'($signed(x));
      KIND_VERTEX: if (slot < VDEPTH) begin
        vtx_x[slot] = longint'($signed(x));
        vtx_y[slot] = longint'($signed(y));
        vtx_z[slot] = longint'($signed(z));
      end
      KIND_INDEX: if (slot < IDEPTH) idx_mem[slot] = iv;
      default: begin
        expected_hits.push_back(predict_hit(longint'($signed(x)), longint'($signed(y))));
        queries_sent++;
      end
    endcase
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_hits.size() != 0) @(negedge clk);
    // loads leave nothing to wait for, allow the pipeline to settle
    repeat (20) @(negedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic [1:0] ri, logic [12:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (ri == CFG_VERTEX_COUNT) vert_count = val[10:0];
    else if (ri == CFG_INDEX_COUNT) index_count = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic query(logic [31:0] x, logic [31:0] y);
    send_item(KIND_QUERY, 12'($urandom), x, y, $urandom, 16'($urandom));
  endtask

  task automatic load_identity(longint w);
    for (int i = 0; i < 16; i++)
      send_item(KIND_MATRIX, 12'(i),
                (i == 0 || i == 5 || i == 10) ? 32'(ONE) : (i == 15 ? 32'(w) : 32'd0),
                $urandom, $urandom, 16'($urandom));
  endtask

  task automatic load_vertex(int s, longint x, longint y, longint z);
    send_item(KIND_VERTEX, 12'(s), 32'(x), 32'(y), 32'(z), 16'($urandom));
  endtask

  task automatic load_index(int s, int v);
    send_item(KIND_INDEX, 12'(s), $urandom, $urandom, $urandom, 16'(v));
  endtask

  // one unit triangle, inside and outside points, clamped extremes
  task automatic test_basic_triangle();
    write_reg(CFG_VERTEX_COUNT, 13'd3);
    write_reg(CFG_INDEX_COUNT, 13'd3);
    load_identity(ONE);
    load_vertex(0, 0, 0, 0);
    load_vertex(1, ONE, 0, 0);
    load_vertex(2, 0, ONE, 0);
    for (int i = 0; i < 3; i++) load_index(i, i);
    query(32'd16384, 32'd16384);
    query(32'd65536, 32'd65536);
    query(32'h8000_0000, 32'h8000_0000);
    query(32'h7fff_ffff, 32'h7fff_ffff);
    // ignored loads: matrix slot past the end, vertex slot past the depth
    send_item(KIND_MATRIX, 12'd4095, 32'hdead_beef, $urandom, $urandom, 16'hffff);
    send_item(KIND_VERTEX, 12'hfff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'hffff);
    query(32'd0, 32'd0);
  endtask

  // empty mesh, trailing triple, bad index, degenerate, w and z culling
  task automatic test_special_cases();
    write_reg(CFG_VERTEX_COUNT, 13'd0);
    query(32'd16384, 32'd16384);
    write_reg(CFG_VERTEX_COUNT, 13'd3);
    write_reg(CFG_INDEX_COUNT, 13'd0);
    query(32'd16384, 32'd16384);
    write_reg(CFG_INDEX_COUNT, 13'd5);
    load_index(3, 0);
    load_index(4, 1);
    query(32'd16384, 32'd16384);
    load_index(2, 65535);
    query(32'd16384, 32'd16384);
    load_index(2, 2);
    load_vertex(2, 2 * ONE, 0, 0);
    query(32'd16384, 32'd0);
    load_vertex(2, 0, ONE, 2 * ONE);
    query(32'd16384, 32'd16384);
    load_vertex(2, 0, ONE, 0);
    load_identity(-ONE);
    query(32'd16384, 32'd16384);
    load_identity(0);
    query(32'd16384, 32'd16384);
    load_identity(ONE);
    query(32'd16384, 32'd16384);
    // out of range register index and extreme counts, followed by a query
    write_reg(2'd2, 13'h1fff);
    write_reg(2'd3, 13'h1fff);
    write_reg(CFG_INDEX_COUNT, 13'h1fff);
    write_reg(CFG_VERTEX_COUNT, 13'h7ff);
    write_reg(CFG_INDEX_COUNT, 13'd3);
    query(32'd16384, 32'd16384);
  endtask

  function automatic longint rnd_range(longint lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  // random small meshes with loads, queries and noise
  task automatic test_random_meshes(int budget);
    int nv, ic, vc, stop_at, nq, v;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      nv = $urandom_range(3, 8);
      ic = $urandom_range(0, 14);
      case ($urandom_range(5))
        0: vc = 1024;
        1: vc = 2047;
        2: vc = $urandom_range(nv, 2047);
        3: vc = $urandom_range(0, nv);
        default: vc = nv;
      endcase
      write_reg(CFG_VERTEX_COUNT, 13'(vc));
      write_reg(CFG_INDEX_COUNT, 13'(ic));
      for (int i = 0; i < 16; i++) begin
        longint m;
        if ($urandom_range(9) == 0) m = longint'($signed($urandom));
        else if (i == 15) m = ONE + rnd_range(16384);
        else if (i == 0 || i == 5 || i == 10) m = ONE + rnd_range(8192);
        else m = rnd_range(8192);
        send_item(KIND_MATRIX, 12'(i), 32'(m), $urandom, $urandom, 16'($urandom));
      end
      for (int i = 0; i < nv; i++) begin
        if ($urandom_range(15) == 0)
          send_item(KIND_VERTEX, 12'(i), $urandom, $urandom, $urandom, 16'($urandom));
        else
          load_vertex(i, rnd_range(98304), rnd_range(98304), rnd_range(80000));
      end
      for (int i = 0; i < ic; i++) begin
        // either a written vertex or one at or past the vertex count
        if ($urandom_range(7) == 0 && vc < 65535) v = $urandom_range(vc, 65535);
        else v = $urandom_range(0, nv - 1);
        load_index(i, v);
      end
      nq = $urandom_range(3, 7);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(7) == 0) query($urandom, $urandom);
        else query(32'(rnd_range(90000)), 32'(rnd_range(90000)));
        // noise loads that leave read entries well defined
        case ($urandom_range(4))
          0: send_item(KIND_MATRIX, 12'($urandom_range(16, 4095)), $urandom, $urandom,
                       $urandom, 16'($urandom));
          1: send_item(KIND_VERTEX, 12'($urandom_range(VDEPTH, 4095)), $urandom, $urandom,
                       $urandom, 16'($urandom));
          2: load_index($urandom_range(ic, 4095), $urandom_range(0, 65535));
          default: ;
        endcase
        if ($urandom_range(19) == 0) wait_drained();
      end
    end
  endtask

  // result side stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tdata[0]) hits_seen++;
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item hit=%0d", $time, out_tdata[0]);
      end else begin
        bit exp_hit;
        exp_hit = expected_hits.pop_front();
        if (out_tdata[0] !== exp_hit) begin
          errors++;
          $display("%0t: hit mismatch expected %0d actual %0d", $time, exp_hit, out_tdata[0]);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    queries_sent = 0;
    hits_seen = 0;
    results_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    vert_count = 0;
    index_count = 0;
    foreach (mat[i]) mat[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_triangle();
    test_special_cases();
    test_random_meshes(250);
    send_idle_pct = 86;
    test_random_meshes(250);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    test_random_meshes(250);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    test_random_meshes(250);
    recv_stall_pct = 0;
    wait_drained();
    repeat (100) @(negedge clk);

    $display("run covered %0d items, %0d queries, %0d results with %0d hits",
             items_sent, queries_sent, results_seen, hits_seen);
    $display("idle phases: none, sender gaps, receiver stalls, both");
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
